// ===== src/cdt_pkg.sv =====
// Package for the countdown timer controller: request and result types,
// machine states and display constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

    localparam logic [7:0] DIGITS_ALL = 8'h3C;
    localparam logic [7:0] POINT_ON   = 8'h10;
    localparam logic [3:0] SEC_ONES_TOP = 4'd9;
    localparam logic [2:0] SEC_TENS_TOP = 3'd5;
    localparam logic [3:0] MIN_ONES_TOP = 4'd9;
    localparam logic [2:0] MIN_TENS_TOP = 3'd5;
    localparam logic [2:0] PHASE_LAST = 3'd7;

    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_REFRESH_RATE = 1'b0;

    typedef enum logic [2:0] {
        ST_STOPPED  = 3'd0,
        ST_STARTED  = 3'd1,
        ST_SET_SO   = 3'd2,
        ST_SET_ST   = 3'd3,
        ST_SET_MO   = 3'd4,
        ST_SET_MT   = 3'd5
    } mode_t;

    typedef struct packed {
        logic btn_up;
        logic btn_down;
        logic btn_set;
        logic btn_start;
        logic btn_bright;
    } btn_req_t;

    typedef struct packed {
        logic [7:0]  digit_enables;
        logic [7:0]  point_enables;
        logic [31:0] digit_word;
        logic [2:0]  brightness_level;
        logic [2:0]  rate_out;
        logic        zero_flag;
        logic [2:0]  mode_state;
    } tick_rsp_t;

endpackage

`default_nettype wire

// ===== src/cdt_core.sv =====
// Per-tick state of the countdown timer: mode machine, BCD digits, blink
// and brightness. Advances one tick per step strobe. Depends on cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdt_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 step,
    input  cdt_pkg::btn_req_t   btn,
    input  wire  [2:0]          refresh_rate,
    output cdt_pkg::tick_rsp_t  rsp
);

    cdt_pkg::mode_t state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] so_reg, so_next;
    logic [2:0] st_reg, st_next;
    logic [3:0] mo_reg, mo_next;
    logic [2:0] mt_reg, mt_next;
    logic       zero_reg, zero_next;
    logic       fast_reg, fast_next;
    logic       slow_reg, slow_next;
    logic       blast_reg, blast_next;
    logic [2:0] level_reg, level_next;
    logic [2:0] shown_reg, shown_next;

    logic [3:0] edit_flags;
    logic [7:0] enables;
    logic       half_tick;
    logic       sec_tick;
    logic [3:0] so_ed, mo_ed;
    logic [2:0] st_ed, mt_ed;

    function automatic logic [3:0] dig_up(input logic [3:0] v, input logic [3:0] top);
        dig_up = (v < top) ? v + 4'd1 : 4'd0;
    endfunction

    function automatic logic [3:0] dig_down(input logic [3:0] v, input logic [3:0] top);
        dig_down = (v != 4'd0) ? v - 4'd1 : top;
    endfunction

    function automatic logic [3:0] dig_edit(input logic [3:0] v, input logic [3:0] top,
                                            input logic up, input logic down);
        if (up)
        begin
            dig_edit = dig_up(v, top);
        end
        else if (down)
        begin
            dig_edit = dig_down(v, top);
        end
        else
        begin
            dig_edit = v;
        end
    endfunction

    // mode machine: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdt_pkg::ST_STOPPED:
            begin
                if (!zero_reg && btn.btn_start)
                    state_next = cdt_pkg::ST_STARTED;
                else if (btn.btn_set)
                    state_next = cdt_pkg::ST_SET_SO;
            end
            cdt_pkg::ST_STARTED:
            begin
                if (zero_reg || btn.btn_start)
                    state_next = cdt_pkg::ST_STOPPED;
            end
            cdt_pkg::ST_SET_SO: if (btn.btn_set) state_next = cdt_pkg::ST_SET_ST;
            cdt_pkg::ST_SET_ST: if (btn.btn_set) state_next = cdt_pkg::ST_SET_MO;
            cdt_pkg::ST_SET_MO: if (btn.btn_set) state_next = cdt_pkg::ST_SET_MT;
            cdt_pkg::ST_SET_MT: if (btn.btn_set) state_next = cdt_pkg::ST_STOPPED;
            default: state_next = state_reg;
        endcase
    end

    // mode machine: blanking flags from the current state
    always_comb
    begin
        case (state_reg)
            cdt_pkg::ST_SET_SO: edit_flags = 4'b0001;
            cdt_pkg::ST_SET_ST: edit_flags = 4'b0010;
            cdt_pkg::ST_SET_MO: edit_flags = 4'b0100;
            cdt_pkg::ST_SET_MT: edit_flags = 4'b1000;
            default:            edit_flags = 4'b0000;
        endcase
    end

    assign enables = (edit_flags == 4'b0000 || fast_reg) ? cdt_pkg::DIGITS_ALL :
                     (~{2'b00, edit_flags, 2'b00} & cdt_pkg::DIGITS_ALL);

    assign half_tick = (phase_reg[1:0] == 2'b11);
    assign sec_tick  = (phase_reg == cdt_pkg::PHASE_LAST);

    always_comb
    begin
        level_next = (!blast_reg && btn.btn_bright) ? level_reg + 3'd1 : level_reg;
        blast_next = btn.btn_bright;
        fast_next  = fast_reg ^ phase_reg[0];
        slow_next  = slow_reg ^ half_tick;
        shown_next = half_tick ? level_next : shown_reg;
        phase_next = phase_reg + 3'd1;

        so_ed = so_reg;
        st_ed = st_reg;
        mo_ed = mo_reg;
        mt_ed = mt_reg;
        if (half_tick)
        begin
            case (state_next)
                cdt_pkg::ST_SET_SO:
                    so_ed = dig_edit(so_reg, cdt_pkg::SEC_ONES_TOP, btn.btn_up, btn.btn_down);
                cdt_pkg::ST_SET_ST:
                    st_ed = 3'(dig_edit({1'b0, st_reg}, {1'b0, cdt_pkg::SEC_TENS_TOP},
                                        btn.btn_up, btn.btn_down));
                cdt_pkg::ST_SET_MO:
                    mo_ed = dig_edit(mo_reg, cdt_pkg::MIN_ONES_TOP, btn.btn_up, btn.btn_down);
                cdt_pkg::ST_SET_MT:
                    mt_ed = 3'(dig_edit({1'b0, mt_reg}, {1'b0, cdt_pkg::MIN_TENS_TOP},
                                        btn.btn_up, btn.btn_down));
                default: ;
            endcase
        end

        so_next = so_ed;
        st_next = st_ed;
        mo_next = mo_ed;
        mt_next = mt_ed;
        // cascaded borrow, once per second while running
        if (sec_tick && state_next == cdt_pkg::ST_STARTED)
        begin
            so_next = dig_down(so_ed, cdt_pkg::SEC_ONES_TOP);
            if (so_ed == 4'd0)
            begin
                st_next = 3'(dig_down({1'b0, st_ed}, {1'b0, cdt_pkg::SEC_TENS_TOP}));
                if (st_ed == 3'd0)
                begin
                    mo_next = dig_down(mo_ed, cdt_pkg::MIN_ONES_TOP);
                    if (mo_ed == 4'd0)
                        mt_next = 3'(dig_down({1'b0, mt_ed},
                                              {1'b0, cdt_pkg::MIN_TENS_TOP}));
                end
            end
        end

        zero_next = (so_next == 4'd0) && (st_next == 3'd0) &&
                    (mo_next == 4'd0) && (mt_next == 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdt_pkg::ST_STOPPED;
            phase_reg <= 3'd0;
            so_reg    <= cdt_pkg::SEC_ONES_TOP;
            st_reg    <= cdt_pkg::SEC_TENS_TOP;
            mo_reg    <= cdt_pkg::MIN_ONES_TOP;
            mt_reg    <= cdt_pkg::MIN_TENS_TOP;
            zero_reg  <= 1'b0;
            fast_reg  <= 1'b0;
            slow_reg  <= 1'b0;
            blast_reg <= 1'b0;
            level_reg <= 3'd3;
            shown_reg <= 3'd3;
        end
        else if (step)
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            so_reg    <= so_next;
            st_reg    <= st_next;
            mo_reg    <= mo_next;
            mt_reg    <= mt_next;
            zero_reg  <= zero_next;
            fast_reg  <= fast_next;
            slow_reg  <= slow_next;
            blast_reg <= blast_next;
            level_reg <= level_next;
            shown_reg <= shown_next;
        end
    end

    always_comb
    begin
        rsp.digit_enables    = enables;
        rsp.point_enables    = slow_next ? cdt_pkg::POINT_ON : 8'h00;
        rsp.digit_word       = {8'h00, 1'b0, mt_next, mo_next, 1'b0, st_next, so_next, 8'h00};
        rsp.brightness_level = shown_next;
        rsp.rate_out         = refresh_rate;
        rsp.zero_flag        = zero_next;
        rsp.mode_state       = state_next;
    end

endmodule

`default_nettype wire

// ===== src/countdown_timer_controller_unit.sv =====
// Top level of the countdown timer controller: request and result
// registers, APB register file. Depends on cdt_pkg and cdt_core.
`timescale 1ns / 1ps
`default_nettype none

// One request is one 125 ms tick with five button levels; each request
// yields exactly one result. A request is taken into the input register;
// then, once the result register is empty or being taken, the tick logic
// updates the timer state and loads the result register. One request is
// accepted every cycle unless the result side stalls, and each result
// waits in the result register until it is taken. The result register
// holds a result while the next request is already waiting in the input
// register. refresh_rate sits at APB offset 0.
module countdown_timer_controller_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  cdt_pkg::btn_req_t   in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output cdt_pkg::tick_rsp_t  out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic               req_valid_reg;
    cdt_pkg::btn_req_t  req_data_reg;
    logic               rsp_valid_reg;
    cdt_pkg::tick_rsp_t rsp_data_reg;
    cdt_pkg::tick_rsp_t rsp_next;
    logic [2:0]         rate_reg;
    logic               advance;
    logic               reg_hit;

    assign advance  = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (out_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_data_reg <= in_data;
        if (advance)
            rsp_data_reg <= rsp_next;
    end

    cdt_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .btn          (req_data_reg),
        .refresh_rate (rate_reg),
        .rsp          (rsp_next)
    );

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_data_reg;

    // APB register file
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2 -: cdt_pkg::REG_IDX_W] == cdt_pkg::REG_REFRESH_RATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 3'd0;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            rate_reg <= pwdata[2:0];
        end
    end

    assign prdata = reg_hit ? {29'd0, rate_reg} : 32'd0;

endmodule

`default_nettype wire
